// ===== hw/rtl/gtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtsc_pkg: shared types and constants for the grid trail score counter
// Grid geometry, walk job record and walk state encoding.
// ----------------------------------------------------------------------------
package gtsc_pkg;

  localparam int unsigned MaxRows   = 64;
  localparam int unsigned MaxCols   = 64;
  localparam int unsigned TopHeight = 9;
  localparam int unsigned CellCap   = MaxRows * MaxCols;
  localparam int unsigned PosW      = $clog2(CellCap);
  localparam int unsigned DimW      = 7;
  localparam int unsigned RowW      = $clog2(MaxRows);
  localparam int unsigned ColW      = $clog2(MaxCols);
  localparam int unsigned DepthW    = $clog2(TopHeight);
  localparam int unsigned SerialW   = 13;
  localparam int unsigned SumW      = 24;
  localparam int unsigned TrailW    = 32;

  // Configuration register indexes
  localparam logic [0:0] RegRows = 1'b0;
  localparam logic [0:0] RegCols = 1'b1;

  // Neighbor directions, tried in this order
  typedef enum logic [2:0] {
    DirUp    = 3'd0,
    DirLeft  = 3'd1,
    DirDown  = 3'd2,
    DirRight = 3'd3,
    DirDone  = 3'd4
  } dir_e;

  typedef enum logic [2:0] {
    WkIdle,
    WkClear,
    WkScan,
    WkStep,
    WkCheck,
    WkDone
  } walk_state_e;

  // Walk request from the loader to the walker
  typedef struct packed {
    logic [RowW:0] rows;
    logic [ColW:0] cols;
  } walk_job_t;

  // Clamp a register value to 1..max
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ===== hw/rtl/gtsc_loader.sv =====
// ----------------------------------------------------------------------------
// gtsc_loader: front part of the grid trail score counter
// Accepts cells, hands store writes to the walker and queues one walk job.
// ----------------------------------------------------------------------------
module gtsc_loader (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,
  output logic                                    full_o,
  input  logic [3:0]                              cell_height_i,
  input  logic                                    last_cell_i,
  input  logic [gtsc_pkg::DimW-1:0]               rows_i,
  input  logic [gtsc_pkg::DimW-1:0]               cols_i,
  input  logic                                    walk_busy_i,
  output logic                                    wr_en_o,
  output logic [gtsc_pkg::PosW-1:0]               wr_addr_o,
  output logic [3:0]                              wr_data_o,
  output logic                                    job_valid_o,
  output gtsc_pkg::walk_job_t                     job_o,
  input  logic                                    job_ready_i
);

  logic [gtsc_pkg::PosW:0] pos_q, pos_d;
  logic                    job_valid_q, job_valid_d;
  gtsc_pkg::walk_job_t     job_q, job_d;
  logic                    acc;
  logic [gtsc_pkg::DimW-1:0] rc, cc;

  // Hold input while a walk job waits or the walk runs
  assign full_o = job_valid_q | walk_busy_i;
  assign acc    = push_i & ~full_o;

  assign rc = gtsc_pkg::clamp_dim(rows_i, gtsc_pkg::DimW'(gtsc_pkg::MaxRows));
  assign cc = gtsc_pkg::clamp_dim(cols_i, gtsc_pkg::DimW'(gtsc_pkg::MaxCols));

  // Write a cell while the store has room
  assign wr_en_o   = acc & (pos_q < (gtsc_pkg::PosW+1)'(gtsc_pkg::CellCap));
  assign wr_addr_o = pos_q[gtsc_pkg::PosW-1:0];
  assign wr_data_o = cell_height_i;

  // Advance the load position and raise a job on the last cell
  always_comb begin
    pos_d       = pos_q;
    job_valid_d = job_valid_q;
    job_d       = job_q;
    if (job_valid_q && job_ready_i) begin
      job_valid_d = 1'b0;
    end
    if (acc) begin
      if (last_cell_i) begin
        pos_d       = '0;
        job_valid_d = 1'b1;
        job_d.rows  = rc[gtsc_pkg::RowW:0];
        job_d.cols  = cc[gtsc_pkg::ColW:0];
      end else if (wr_en_o) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// ===== hw/rtl/gtsc_walker.sv =====
// ----------------------------------------------------------------------------
// gtsc_walker: back part of the grid trail score counter
// Holds the height and stamp stores and runs the depth-first trail walk.
// ----------------------------------------------------------------------------
module gtsc_walker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [gtsc_pkg::PosW-1:0]      wr_addr_i,
  input  logic [3:0]                     wr_data_i,
  input  logic                           job_valid_i,
  input  gtsc_pkg::walk_job_t            job_i,
  output logic                           job_ready_o,
  output logic                           busy_o,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [gtsc_pkg::SumW-1:0]      summit_o,
  output logic [gtsc_pkg::TrailW-1:0]    trail_o
);

  localparam int unsigned PW = gtsc_pkg::PosW;
  localparam int unsigned RW = gtsc_pkg::RowW;
  localparam int unsigned CW = gtsc_pkg::ColW;
  localparam int unsigned DW = gtsc_pkg::DepthW;
  localparam int unsigned SW = gtsc_pkg::SerialW;

  // Stores
  logic [3:0]    height_mem [gtsc_pkg::CellCap];
  logic [SW-1:0] stamp_mem  [gtsc_pkg::CellCap];
  logic [3:0]    h_rd_q;
  logic [SW-1:0] s_rd_q;

  // Walk stack: row, column, cell position and next direction per level
  logic [RW-1:0]        st_r_q [gtsc_pkg::TopHeight];
  logic [CW-1:0]        st_c_q [gtsc_pkg::TopHeight];
  logic [PW-1:0]        st_p_q [gtsc_pkg::TopHeight];
  gtsc_pkg::dir_e       st_d_q [gtsc_pkg::TopHeight];

  gtsc_pkg::walk_state_e state_q, state_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic [RW:0]     rows_q;
  logic [CW:0]     cols_q;
  logic [RW-1:0]   sr_q, sr_d;
  logic [CW-1:0]   sc_q, sc_d;
  logic [PW-1:0]   sp_q, sp_d;
  logic [PW-1:0]   clr_q, clr_d;
  logic [SW-1:0]   serial_q, serial_d;
  logic [SW:0]     distinct_q, distinct_d;
  logic [gtsc_pkg::SumW-1:0]   sum_q, sum_d;
  logic [gtsc_pkg::TrailW-1:0] trail_q, trail_d;
  logic [RW-1:0]   qr_q, qr_d;
  logic [CW-1:0]   qc_q, qc_d;
  logic [PW-1:0]   qp_q, qp_d;
  logic            res_q, res_d;

  // Read address and stamp write
  logic [PW-1:0]   rd_addr;
  logic            st_we;
  logic [PW-1:0]   st_waddr;
  logic [SW-1:0]   st_wdata;
  logic            push_lvl, pop_lvl, dir_adv;
  logic [RW-1:0]   cur_r;
  logic [CW-1:0]   cur_c;
  logic [PW-1:0]   cur_p;
  gtsc_pkg::dir_e  cur_d;
  logic            nb_ok;
  logic [RW-1:0]   nb_r;
  logic [CW-1:0]   nb_c;
  logic [PW-1:0]   nb_p;
  logic [gtsc_pkg::SumW:0] sum_add;

  assign cur_r = st_r_q[depth_q];
  assign cur_c = st_c_q[depth_q];
  assign cur_p = st_p_q[depth_q];
  assign cur_d = st_d_q[depth_q];

  // Pick the neighbor for the current direction
  always_comb begin
    nb_ok = 1'b0;
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_p  = cur_p;
    case (cur_d)
      gtsc_pkg::DirUp: begin
        nb_ok = (cur_r != '0);
        nb_r  = cur_r - 1'b1;
        nb_p  = cur_p - PW'(cols_q);
      end
      gtsc_pkg::DirLeft: begin
        nb_ok = (cur_c != '0);
        nb_c  = cur_c - 1'b1;
        nb_p  = cur_p - 1'b1;
      end
      gtsc_pkg::DirDown: begin
        nb_ok = ((RW+1)'(cur_r) + 1'b1 < rows_q);
        nb_r  = cur_r + 1'b1;
        nb_p  = cur_p + PW'(cols_q);
      end
      gtsc_pkg::DirRight: begin
        nb_ok = ((CW+1)'(cur_c) + 1'b1 < cols_q);
        nb_c  = cur_c + 1'b1;
        nb_p  = cur_p + 1'b1;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // Read the neighbor while stepping, else the next scan cell
  always_comb begin
    case (state_q)
      gtsc_pkg::WkStep:  rd_addr = (cur_d != gtsc_pkg::DirDone) ? nb_p : sp_d;
      default:           rd_addr = sp_d;
    endcase
  end

  // Store ports
  always_ff @(posedge clk_i) begin
    if (wr_en_i) height_mem[wr_addr_i] <= wr_data_i;
    h_rd_q <= height_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) stamp_mem[st_waddr] <= st_wdata;
    s_rd_q <= stamp_mem[rd_addr];
  end

  assign sum_add = (gtsc_pkg::SumW+1)'(sum_q) + (gtsc_pkg::SumW+1)'(distinct_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gtsc_pkg::WkIdle:  if (job_valid_i && !res_q) state_d = gtsc_pkg::WkClear;
      gtsc_pkg::WkClear: if (clr_q == PW'(gtsc_pkg::CellCap - 1)) state_d = gtsc_pkg::WkScan;
      gtsc_pkg::WkScan: begin
        if (h_rd_q == 4'd0) state_d = gtsc_pkg::WkStep;
        else if ((RW+1)'(sr_q) + 1'b1 >= rows_q && (CW+1)'(sc_q) + 1'b1 >= cols_q)
          state_d = gtsc_pkg::WkDone;
      end
      gtsc_pkg::WkStep: begin
        if (cur_d == gtsc_pkg::DirDone && depth_q == '0) begin
          if ((RW+1)'(sr_q) + 1'b1 >= rows_q && (CW+1)'(sc_q) + 1'b1 >= cols_q)
            state_d = gtsc_pkg::WkDone;
          else state_d = gtsc_pkg::WkScan;
        end else if (cur_d != gtsc_pkg::DirDone && nb_ok) begin
          state_d = gtsc_pkg::WkCheck;
        end
      end
      gtsc_pkg::WkCheck: state_d = gtsc_pkg::WkStep;
      gtsc_pkg::WkDone:  state_d = gtsc_pkg::WkIdle;
      default:           state_d = gtsc_pkg::WkIdle;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    depth_d    = depth_q;
    sr_d       = sr_q;
    sc_d       = sc_q;
    sp_d       = sp_q;
    clr_d      = clr_q;
    serial_d   = serial_q;
    distinct_d = distinct_q;
    sum_d      = sum_q;
    trail_d    = trail_q;
    qr_d       = qr_q;
    qc_d       = qc_q;
    qp_d       = qp_q;
    res_d      = res_q;
    st_we      = 1'b0;
    st_waddr   = qp_q;
    st_wdata   = serial_q;
    push_lvl   = 1'b0;
    pop_lvl    = 1'b0;
    dir_adv    = 1'b0;
    job_ready_o = 1'b0;
    if (res_q && res_ready_i) res_d = 1'b0;
    case (state_q)
      gtsc_pkg::WkIdle: begin
        if (job_valid_i && !res_q) begin
          job_ready_o = 1'b1;
          clr_d    = '0;
          sum_d    = '0;
          trail_d  = '0;
          serial_d = '0;
        end
      end
      gtsc_pkg::WkClear: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = '0;
        clr_d    = clr_q + 1'b1;
        sr_d     = '0;
        sc_d     = '0;
        sp_d     = '0;
      end
      gtsc_pkg::WkScan: begin
        if (h_rd_q == 4'd0) begin
          serial_d   = serial_q + 1'b1;
          distinct_d = '0;
          depth_d    = '0;
          push_lvl   = 1'b1;
        end else if ((CW+1)'(sc_q) + 1'b1 >= cols_q) begin
          sc_d = '0;
          sr_d = sr_q + 1'b1;
          sp_d = sp_q + 1'b1;
        end else begin
          sc_d = sc_q + 1'b1;
          sp_d = sp_q + 1'b1;
        end
      end
      gtsc_pkg::WkStep: begin
        if (cur_d == gtsc_pkg::DirDone) begin
          if (depth_q == '0) begin
            sum_d = sum_add[gtsc_pkg::SumW] ? '1 : sum_add[gtsc_pkg::SumW-1:0];
            sp_d  = sp_q + 1'b1;
            if ((CW+1)'(sc_q) + 1'b1 >= cols_q) begin
              sc_d = '0;
              sr_d = sr_q + 1'b1;
            end else begin
              sc_d = sc_q + 1'b1;
            end
          end else begin
            pop_lvl = 1'b1;
            depth_d = depth_q - 1'b1;
          end
        end else begin
          dir_adv = 1'b1;
          qr_d    = nb_r;
          qc_d    = nb_c;
          qp_d    = nb_p;
        end
      end
      gtsc_pkg::WkCheck: begin
        if (h_rd_q == 4'((32)'(depth_q) + 1)) begin
          if (32'(depth_q) + 1 >= gtsc_pkg::TopHeight) begin
            if (trail_q != '1) trail_d = trail_q + 1'b1;
            if (s_rd_q != serial_q) begin
              st_we      = 1'b1;
              distinct_d = distinct_q + 1'b1;
            end
          end else begin
            depth_d  = depth_q + 1'b1;
            push_lvl = 1'b1;
          end
        end
      end
      gtsc_pkg::WkDone: res_d = 1'b1;
      default: ;
    endcase
  end

  // Walk stack
  always_ff @(posedge clk_i) begin
    if (push_lvl) begin
      st_r_q[depth_d] <= (state_q == gtsc_pkg::WkScan) ? sr_q : qr_q;
      st_c_q[depth_d] <= (state_q == gtsc_pkg::WkScan) ? sc_q : qc_q;
      st_p_q[depth_d] <= (state_q == gtsc_pkg::WkScan) ? sp_q : qp_q;
      st_d_q[depth_d] <= gtsc_pkg::DirUp;
    end
    if (dir_adv) st_d_q[depth_q] <= gtsc_pkg::dir_e'(cur_d + 3'd1);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == gtsc_pkg::WkIdle && job_valid_i && !res_q) begin
      rows_q <= job_i.rows;
      cols_q <= job_i.cols;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gtsc_pkg::WkIdle;
      depth_q    <= '0;
      sr_q       <= '0;
      sc_q       <= '0;
      sp_q       <= '0;
      clr_q      <= '0;
      serial_q   <= '0;
      distinct_q <= '0;
      sum_q      <= '0;
      trail_q    <= '0;
      qr_q       <= '0;
      qc_q       <= '0;
      qp_q       <= '0;
      res_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      depth_q    <= depth_d;
      sr_q       <= sr_d;
      sc_q       <= sc_d;
      sp_q       <= sp_d;
      clr_q      <= clr_d;
      serial_q   <= serial_d;
      distinct_q <= distinct_d;
      sum_q      <= sum_d;
      trail_q    <= trail_d;
      qr_q       <= qr_d;
      qc_q       <= qc_d;
      qp_q       <= qp_d;
      res_q      <= res_d;
    end
  end

  assign busy_o      = (state_q != gtsc_pkg::WkIdle);
  assign res_valid_o = res_q;
  assign summit_o    = sum_q;
  assign trail_o     = trail_q;

endmodule

// ===== hw/rtl/grid_trail_score_counter.sv =====
// ----------------------------------------------------------------------------
// grid_trail_score_counter: top level
// Loads a height grid and counts hiking trails from each height-0 cell.
// ----------------------------------------------------------------------------
// Usage:
//   Push grid cells in row-major order on the input queue (push/full),
//   one per cycle. The cell flagged with last_cell_i starts the walk.
//   The configuration channel (cfg_valid_i/cfg_ready_o) sets grid rows
//   (index 0) and columns (index 1); write it only while idle.
// Flow:
//   Cells transfer at one per cycle while no job waits and no walk runs. Once
//   idle with no result pending, the walker takes the job, clears the
//   4096-entry stamp store, then scans the grid one cell per cycle between walks.
//   In the walk each in-grid neighbor passes a step and a check state; each
//   off-grid direction, backtrack and trailhead close a step state; a done state
//   raises the result. Input is held full from the last cell until the walk ends.
// Result:
//   One result per last cell appears on the output queue (empty/pop)
//   and stays until popped; a stalled receiver holds the walker in idle.
// Reset:
//   Clears control state and the registers to 64 by 64; the height store
//   holds no defined values until written.
// ----------------------------------------------------------------------------
module grid_trail_score_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [3:0]                    cell_height_i,
  input  logic                          last_cell_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [23:0]                   distinct_summit_total_o,
  output logic [31:0]                   trail_total_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [6:0]                    cfg_data_i
);

  logic [gtsc_pkg::DimW-1:0] rows_q, cols_q;
  logic                      wr_en;
  logic [gtsc_pkg::PosW-1:0] wr_addr;
  logic [3:0]                wr_data;
  logic                      job_valid, job_ready, res_valid, walk_busy;
  gtsc_pkg::walk_job_t       job;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gtsc_pkg::DimW'(64);
      cols_q <= gtsc_pkg::DimW'(64);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gtsc_pkg::RegRows: rows_q <= cfg_data_i;
        gtsc_pkg::RegCols: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gtsc_loader u_loader (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .cell_height_i (cell_height_i),
    .last_cell_i   (last_cell_i),
    .rows_i        (rows_q),
    .cols_i        (cols_q),
    .walk_busy_i   (walk_busy),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .job_valid_o   (job_valid),
    .job_o         (job),
    .job_ready_i   (job_ready)
  );

  gtsc_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .busy_o      (walk_busy),
    .res_valid_o (res_valid),
    .res_ready_i (pop),
    .summit_o    (distinct_summit_total_o),
    .trail_o     (trail_total_o)
  );

  assign empty = ~res_valid;

endmodule

// ===== sim/gtsc_checker.sv =====
// ----------------------------------------------------------------------------
// gtsc_checker: scoreboard for the grid trail score counter
// Watches the cell, result and register channels, keeps its own copy of the
// height grid, counts trails after each last cell and compares every result.
// ----------------------------------------------------------------------------
module gtsc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [3:0]  cell_height_i,
  input  logic        last_cell_i,
  input  logic        pop_i,
  input  logic        empty_i,
  input  logic [23:0] distinct_summit_total_i,
  input  logic [31:0] trail_total_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [23:0] summits;
    logic [31:0] trails;
  } score_t;

  logic [3:0]   height_mem [gtsc_pkg::CellCap];
  logic [6:0]   rows_reg;
  logic [6:0]   cols_reg;
  int           load_pos;
  score_t       score_q[$];

  initial begin
    foreach (height_mem[i]) height_mem[i] = 4'd0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int fit_dim(logic [6:0] v, int maxv);
    if (v == 7'd0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Depth-first walk from every height-0 cell, up/left/down/right order
  function automatic score_t count_trails();
    score_t   res;
    int       rows, cols, n, serial, depth, cur, r, c, q, dir, distinct;
    int       pos_stk [gtsc_pkg::TopHeight];
    int       dir_stk [gtsc_pkg::TopHeight];
    int       stamp   [gtsc_pkg::CellCap];
    longint   summits, trails;
    rows = fit_dim(rows_reg, gtsc_pkg::MaxRows);
    cols = fit_dim(cols_reg, gtsc_pkg::MaxCols);
    n = rows * cols;
    serial = 0;
    summits = 0;
    trails = 0;
    foreach (stamp[i]) stamp[i] = 0;
    for (int p = 0; p < n; p++) begin
      if (height_mem[p] != 4'd0) continue;
      serial++;
      distinct = 0;
      depth = 0;
      pos_stk[0] = p;
      dir_stk[0] = 0;
      while (depth >= 0) begin
        cur = pos_stk[depth];
        r = cur / cols;
        c = cur % cols;
        dir = dir_stk[depth];
        if (dir >= 4) begin
          depth--;
          continue;
        end
        dir_stk[depth] = dir + 1;
        case (dir)
          0: begin
            if (r == 0) continue;
            q = cur - cols;
          end
          1: begin
            if (c == 0) continue;
            q = cur - 1;
          end
          2: begin
            if (r + 1 >= rows) continue;
            q = cur + cols;
          end
          default: begin
            if (c + 1 >= cols) continue;
            q = cur + 1;
          end
        endcase
        if (q >= gtsc_pkg::CellCap) continue;
        if (int'(height_mem[q]) != depth + 1) continue;
        if (depth + 1 >= gtsc_pkg::TopHeight) begin
          if (trails != 64'hFFFF_FFFF) trails++;
          if (stamp[q] != serial) begin
            stamp[q] = serial;
            distinct++;
          end
        end else begin
          depth++;
          pos_stk[depth] = q;
          dir_stk[depth] = 0;
        end
      end
      summits += distinct;
      if (summits > 64'hFF_FFFF) summits = 64'hFF_FFFF;
    end
    res.summits = summits[23:0];
    res.trails  = trails[31:0];
    return res;
  endfunction

  // Track register writes, store cells and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    score_t got, want;
    if (!rst_ni) begin
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      load_pos = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == gtsc_pkg::RegRows) rows_reg = cfg_data_i;
        else if (cfg_index_i == gtsc_pkg::RegCols) cols_reg = cfg_data_i;
      end
      if (push_i && !full_i) begin
        if (load_pos < gtsc_pkg::CellCap) begin
          height_mem[load_pos] = cell_height_i;
          load_pos = load_pos + 1;
        end
        if (last_cell_i) begin
          score_q = {score_q, count_trails()};
          load_pos = 0;
        end
      end
      if (pop_i && !empty_i) begin
        got.summits = distinct_summit_total_i;
        got.trails  = trail_total_i;
        if (score_q.size() == 0) begin
          $error("result transfer with no expected score pending");
          fail_count_o++;
        end else begin
          want = score_q.pop_front();
          if (got.summits !== want.summits) begin
            $error("distinct_summit_total: expected %0d, got %0d", want.summits, got.summits);
            fail_count_o++;
          end
          if (got.trails !== want.trails) begin
            $error("trail_total: expected %0d, got %0d", want.trails, got.trails);
            fail_count_o++;
          end
        end
      end
      pending_o <= score_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the grid trail score counter
// Loads directed and random height grids under varying register settings and
// idle patterns; the checker predicts and compares every score.
// ----------------------------------------------------------------------------
module tb;

  localparam int WatchLimit = 400000;
  localparam int HoldCycles = 12000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [3:0]  cell_height_i;
  logic        last_cell_i;
  logic        empty;
  logic        pop;
  logic [23:0] distinct_summit_total_o;
  logic [31:0] trail_total_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [6:0]  cfg_data_i;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int cells_sent;
  int grid_r;
  int grid_c;
  int idle_cycles;

  grid_trail_score_counter DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .push                   (push),
    .full                   (full),
    .cell_height_i          (cell_height_i),
    .last_cell_i            (last_cell_i),
    .empty                  (empty),
    .pop                    (pop),
    .distinct_summit_total_o(distinct_summit_total_o),
    .trail_total_o          (trail_total_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  gtsc_checker u_checker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .push_i                 (push),
    .full_i                 (full),
    .cell_height_i          (cell_height_i),
    .last_cell_i            (last_cell_i),
    .pop_i                  (pop),
    .empty_i                (empty),
    .distinct_summit_total_i(distinct_summit_total_o),
    .trail_total_i          (trail_total_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_i            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .fail_count_o           (fail_count),
    .pending_o              (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        for (int k = 0; k < HoldCycles; k++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int fit_dim(int v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // Transfer one cell, idling the sender at random first
  task automatic send_cell(input logic [3:0] h, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    cell_height_i <= h;
    last_cell_i   <= last;
    do @(posedge clk_i); while (full);
    cells_sent++;
  endtask

  // Write one register once every score has drained
  task automatic write_reg(input logic [0:0] idx, input int val);
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || !empty);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 7'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gtsc_pkg::RegRows) grid_r = fit_dim(val);
    else grid_c = fit_dim(val);
  endtask

  // Load one grid: ramps give long trails, noise covers odd heights
  task automatic load_grid(input int len, input int kind);
    int off, r, c, h;
    off = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      r = i / grid_c;
      c = i % grid_c;
      case (kind)
        0: h = (r + c + off) % 10;
        1: h = 9 - ((r + c + off) % 10);
        default: h = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(10);
      endcase
      if (kind < 2 && $urandom_range(99) < 8) h = $urandom_range(15);
      send_cell(4'(h), i == len - 1);
    end
  endtask

  task automatic send_row(input int n, input logic [3:0] h [10]);
    for (int i = 0; i < n; i++) send_cell(h[i], i == n - 1);
  endtask

  initial begin
    logic [3:0] row [10];
    int n, len, target;
    bit hold_done;
    rst_ni        = 1'b0;
    push          = 1'b0;
    cell_height_i = 4'd0;
    last_cell_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = gtsc_pkg::RegRows;
    cfg_data_i    = 7'd0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    cells_sent    = 0;
    grid_r        = 64;
    grid_c        = 64;
    idle_cycles   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tall column: rows saturated from above, columns zero
    write_reg(gtsc_pkg::RegRows, 127);
    write_reg(gtsc_pkg::RegCols, 0);
    load_grid(64, 0);
    // Wide row: rows zero, columns saturated from above
    write_reg(gtsc_pkg::RegRows, 0);
    write_reg(gtsc_pkg::RegCols, 127);
    load_grid(64, 1);
    // Single cell grid from zero registers
    write_reg(gtsc_pkg::RegCols, 0);
    send_cell(4'd0, 1'b1);
    // One row ramp 0..9 and one column ramp
    write_reg(gtsc_pkg::RegCols, 10);
    row = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9};
    send_row(10, row);
    write_reg(gtsc_pkg::RegCols, 1);
    write_reg(gtsc_pkg::RegRows, 10);
    send_row(10, row);
    // Non-digit and high heights break the ramp
    write_reg(gtsc_pkg::RegRows, 1);
    write_reg(gtsc_pkg::RegCols, 10);
    row = '{4'd0, 4'd1, 4'd10, 4'd15, 4'd4, 4'd8, 4'd9, 4'd11, 4'd12, 4'd0};
    send_row(10, row);
    // Short load reuses old cells; long load adds ignored cells
    write_reg(gtsc_pkg::RegRows, 3);
    write_reg(gtsc_pkg::RegCols, 3);
    load_grid(4, 2);
    load_grid(14, 0);

    // Random grids over four idle phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      target = cells_sent + 300;
      while (cells_sent < target) begin
        if ($urandom_range(9) < 7) begin
          write_reg(gtsc_pkg::RegRows,
                    ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8));
          write_reg(gtsc_pkg::RegCols,
                    ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 8));
        end
        n = grid_r * grid_c;
        case ($urandom_range(9))
          0: len = n + $urandom_range(1, 5);
          1: len = $urandom_range(1, n);
          default: len = n;
        endcase
        // Long receiver hold-off while several grids keep coming
        if (ph == 0 && !hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        load_grid(len, ($urandom_range(9) < 8) ? $urandom_range(1) : 2);
        if (ph == 0 && hold_req) begin
          load_grid(len, 0);
          load_grid(len, 1);
        end
      end
    end
    push <= 1'b0;

    do @(posedge clk_i); while (pending != 0 || !empty);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
